/* rtl/gnpa_pkg.sv */
// shared constants and types for the gaussian noise pixel adder
`default_nettype none
package gnpa_pkg;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [32:0] TWO_LN2_Q32 = 33'd5954088944;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	localparam int LOG_FRAC_BITS = 24;
	localparam int COS_TERMS = 7;
	localparam int SIN_TERMS = 5;

	// horner divisors, innermost term first
	localparam int unsigned COS_DIV [COS_TERMS] = '{182, 132, 90, 56, 30, 12, 2};
	localparam int unsigned SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};

	typedef enum logic [0:0] {
		CFG_MEAN     = 1'b0,
		CFG_VARIANCE = 1'b1
	} cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/gnpa_delay.sv */
// stallable delay line of pipeline registers
`default_nettype none
module gnpa_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];

endmodule
`default_nettype wire

/* rtl/gnpa_log_cell.sv */
// one squaring step of the log2 mantissa, yields one fraction bit
`default_nettype none
module gnpa_log_cell #(
	parameter int BIT = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [4:0]  e_i,
	input  wire logic [30:0] m_i,
	input  wire logic [23:0] frac_i,
	output logic      [4:0]  e_o,
	output logic      [30:0] m_o,
	output logic      [23:0] frac_o
);

	logic [61:0] sq;
	logic [31:0] t;
	logic [30:0] m_nx;
	logic [23:0] frac_nx;

	always_comb begin
		sq = 62'(m_i) * 62'(m_i);
		t = sq[61:30];
		frac_nx = frac_i;
		frac_nx[BIT] = t[31];
		// square reached two: renormalize
		m_nx = t[31] ? t[31:1] : t[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_o <= e_i;
			m_o <= m_nx;
			frac_o <= frac_nx;
		end
	end

endmodule
`default_nettype wire

/* rtl/gnpa_sqrt_cell.sv */
// one digit step of a restoring integer square root
`default_nettype none
module gnpa_sqrt_cell #(
	parameter int VW = 38
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [VW-1:0]   v_i,
	input  wire logic [VW/2:0]   rem_i,
	input  wire logic [VW/2-1:0] root_i,
	output logic      [VW-1:0]   v_o,
	output logic      [VW/2:0]   rem_o,
	output logic      [VW/2-1:0] root_o
);

	localparam int RW = VW / 2;

	logic [RW+2:0] cur;
	logic [RW+2:0] trial;
	logic          take;

	always_comb begin
		cur = {rem_i, v_i[VW-1:VW-2]};
		trial = {1'b0, root_i, 2'b01};
		take = (cur >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_o <= {v_i[VW-3:0], 2'b00};
			rem_o <= take ? (RW+1)'(cur - trial) : (RW+1)'(cur);
			root_o <= {root_i[RW-2:0], take};
		end
	end

endmodule
`default_nettype wire

/* rtl/gnpa_horner_cell.sv */
// one horner term h' = 1 - (x2*h)/K in q30, three stages
`default_nettype none
module gnpa_horner_cell #(
	parameter int unsigned K = 2
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [29:0] x2_i,
	input  wire logic [30:0] h_i,
	output logic      [29:0] x2_o,
	output logic      [30:0] h_o
);

	localparam logic [63:0] MUL64 = (64'd1 << 30) / 64'(K);
	localparam logic [29:0] MUL = MUL64[29:0];

	logic [60:0] prod;
	logic [29:0] p_s1, p_s2;
	logic [29:0] x2_s1, x2_s2;
	logic [59:0] t_s2;
	logic [29:0] q0;
	logic [37:0] qk;
	logic [29:0] rem;
	logic [29:0] q;

	assign prod = 61'(x2_i) * 61'(h_i);

	always_comb begin
		q0 = t_s2[59:30];
		qk = 38'(q0) * 38'(K);
		rem = p_s2 - qk[29:0];
		// reciprocal estimate is at most one low
		q = (rem >= 30'(K)) ? q0 + 30'd1 : q0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= prod[59:30];
			x2_s1 <= x2_i;
			t_s2 <= 60'(p_s1) * 60'(MUL);
			p_s2 <= p_s1;
			x2_s2 <= x2_s1;
			h_o <= gnpa_pkg::Q30_ONE - {1'b0, q};
			x2_o <= x2_s2;
		end
	end

endmodule
`default_nettype wire

/* rtl/gaussian_noise_pixel_adder.sv */
// Gaussian noise pixel adder: Box-Muller noise added to a grey pixel stream.
//
// Input stream s_axis carries one pixel and two raw uniform words per transfer;
// output stream m_axis carries the noisy pixel. One result per input, in order.
// noise_mean (Q9.8 signed) and noise_variance (Q16.8) are written over the cfg
// port while the stream is idle; they are read as items pass through.
// Throughput is one item per clock unless the output stalls: every unit is a
// row of cells that hand their partial result to the next cell each enabled
// cycle (24 log2 squaring cells, 19 and 24 square root digit cells, 12
// three-stage horner cells for cos and sin).
// The output has a register plus one skid entry. When the receiver stalls, the
// result waits in the output register, the next one lands in the skid entry
// and the whole pipeline then holds until the skid drains; s_axis_tready is a
// register output and does not depend on m_axis_tready combinationally.
// Reset clears all valid bits and sets mean to 0 and variance to 100.0.
`default_nettype none
module gaussian_noise_pixel_adder #(
	parameter int UNIFORM_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // pixel_in, uniform_a, uniform_b
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // pixel_out
	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata
);

	localparam int DEPTH = 49;
	localparam logic [15:0] WORD_MASK = (UNIFORM_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << UNIFORM_BITS) - 32'd1);
	localparam logic [16:0] PH_MASK = (UNIFORM_BITS >= 17) ? 17'h1FFFF :
		17'((33'd1 << UNIFORM_BITS) - 33'd1);
	localparam int PH_SHIFT = 32 - UNIFORM_BITS;
	localparam logic [29:0] BITS_Q24 = 30'(UNIFORM_BITS) << 24;

	// configuration
	logic signed [16:0] mean_q;
	logic [23:0]        variance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			variance_q <= 24'd25600;
		end else if (cfg_wr_en) begin
			unique case (gnpa_pkg::cfg_reg_t'(cfg_addr))
				gnpa_pkg::CFG_MEAN:     mean_q <= cfg_wdata[16:0];
				gnpa_pkg::CFG_VARIANCE: variance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// flow control
	logic             en;
	logic             take;
	logic             push;
	logic             fire;
	logic [DEPTH:1]   valid_s;
	logic             out_v_q, skid_v_q;
	logic [7:0]       out_d_q, skid_d_q;
	logic [7:0]       res;

	assign en = ~skid_v_q;
	assign s_axis_tready = en;
	assign take = s_axis_tvalid & en;
	assign push = en & valid_s[DEPTH];
	assign fire = out_v_q & m_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DEPTH-1:1], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || fire) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || fire) begin
			out_d_q <= skid_v_q ? skid_d_q : res;
		end else if (push) begin
			skid_d_q <= res;
		end
	end

	// stage 1: capture
	logic [7:0]  pix_s1;
	logic [15:0] a_s1, b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= s_axis_tdata[7:0];
			a_s1 <= s_axis_tdata[23:8] & WORD_MASK;
			b_s1 <= s_axis_tdata[39:24] & WORD_MASK;
		end
	end

	// stage 2: log2 normalize, phase to octant
	logic [16:0] x;
	logic [4:0]  e;
	logic [47:0] m_wide;
	logic [16:0] inc;
	logic [31:0] ph;
	logic [2:0]  oct, oct_p1;
	logic [3:0]  oct_p2;
	logic [29:0] r;
	logic [4:0]  e_s2;
	logic [30:0] m_s2;
	logic [29:0] r_s2;
	logic        neg_s2, sel_s2;

	always_comb begin
		x = {1'b0, a_s1} + 17'd1;
		e = '0;
		for (int i = 0; i < 17; i++) begin
			if (x[i]) e = 5'(i);
		end
		m_wide = 48'(x) << (5'd30 - e);
		inc = ({1'b0, b_s1} + 17'd1) & PH_MASK;
		ph = 32'(inc) << PH_SHIFT;
		oct = ph[31:29];
		// odd octants mirror the angle
		r = oct[0] ? (30'd1 << 29) - {1'b0, ph[28:0]} : {1'b0, ph[28:0]};
		oct_p2 = {1'b0, oct} + 4'd2;
		oct_p1 = oct + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2 <= e;
			m_s2 <= m_wide[30:0];
			r_s2 <= r;
			neg_s2 <= oct_p2[2];
			sel_s2 <= oct_p1[1];
		end
	end

	// log2 chain: stages 3..26
	logic [4:0]  lg_e [gnpa_pkg::LOG_FRAC_BITS+1];
	logic [30:0] lg_m [gnpa_pkg::LOG_FRAC_BITS+1];
	logic [23:0] lg_f [gnpa_pkg::LOG_FRAC_BITS+1];

	assign lg_e[0] = e_s2;
	assign lg_m[0] = m_s2;
	assign lg_f[0] = '0;

	for (genvar k = 0; k < gnpa_pkg::LOG_FRAC_BITS; k++) begin : g_log
		gnpa_log_cell #(
			.BIT(gnpa_pkg::LOG_FRAC_BITS - 1 - k)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.e_i   (lg_e[k]),
			.m_i   (lg_m[k]),
			.frac_i(lg_f[k]),
			.e_o   (lg_e[k+1]),
			.m_o   (lg_m[k+1]),
			.frac_o(lg_f[k+1])
		);
	end

	// stage 27: -2 ln u1 in q24
	logic [29:0] lval;
	logic [62:0] lprod;
	logic [29:0] s24_s27;

	always_comb begin
		lval = BITS_Q24 - {1'b0, lg_e[gnpa_pkg::LOG_FRAC_BITS], lg_f[gnpa_pkg::LOG_FRAC_BITS]};
		lprod = 63'(lval) * 63'(gnpa_pkg::TWO_LN2_Q32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s24_s27 <= lprod[61:32];
		end
	end

	// radius square root: stages 28..46
	logic [37:0] rv   [20];
	logic [19:0] rrem [20];
	logic [18:0] rrt  [20];

	assign rv[0] = {s24_s27, 8'b0};
	assign rrem[0] = '0;
	assign rrt[0] = '0;

	for (genvar k = 0; k < 19; k++) begin : g_rad
		gnpa_sqrt_cell #(.VW(38)) u_cell (
			.clk   (clk),
			.en    (en),
			.v_i   (rv[k]),
			.rem_i (rrem[k]),
			.root_i(rrt[k]),
			.v_o   (rv[k+1]),
			.rem_o (rrem[k+1]),
			.root_o(rrt[k+1])
		);
	end

	// std deviation square root: stages 1..24, fed from the register
	logic [47:0] sv   [25];
	logic [24:0] srem [25];
	logic [23:0] srt  [25];

	assign sv[0] = {variance_q, 24'b0};
	assign srem[0] = '0;
	assign srt[0] = '0;

	for (genvar k = 0; k < 24; k++) begin : g_sd
		gnpa_sqrt_cell #(.VW(48)) u_cell (
			.clk   (clk),
			.en    (en),
			.v_i   (sv[k]),
			.rem_i (srem[k]),
			.root_i(srt[k]),
			.v_o   (sv[k+1]),
			.rem_o (srem[k+1]),
			.root_o(srt[k+1])
		);
	end

	// angle: stages 3, 4
	logic [61:0] thprod;
	logic [59:0] x2prod;
	logic [29:0] th_s3, th_s4, x2_s4;

	assign thprod = 62'(r_s2) * 62'(gnpa_pkg::PI_Q30);
	assign x2prod = 60'(th_s3) * 60'(th_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			th_s3 <= thprod[60:31];
			th_s4 <= th_s3;
			x2_s4 <= x2prod[59:30];
		end
	end

	// cos series: stages 5..25
	logic [29:0] cx2 [gnpa_pkg::COS_TERMS+1];
	logic [30:0] ch  [gnpa_pkg::COS_TERMS+1];

	assign cx2[0] = x2_s4;
	assign ch[0] = gnpa_pkg::Q30_ONE;

	for (genvar k = 0; k < gnpa_pkg::COS_TERMS; k++) begin : g_cos
		gnpa_horner_cell #(.K(gnpa_pkg::COS_DIV[k])) u_cell (
			.clk (clk),
			.en  (en),
			.x2_i(cx2[k]),
			.h_i (ch[k]),
			.x2_o(cx2[k+1]),
			.h_o (ch[k+1])
		);
	end

	// sin series: stages 5..19, then times theta at stage 20
	logic [29:0] sx2 [gnpa_pkg::SIN_TERMS+1];
	logic [30:0] sh  [gnpa_pkg::SIN_TERMS+1];
	logic [29:0] th_s19;
	logic [60:0] snprod;
	logic [30:0] sn_s20, sn_s25;

	assign sx2[0] = x2_s4;
	assign sh[0] = gnpa_pkg::Q30_ONE;

	for (genvar k = 0; k < gnpa_pkg::SIN_TERMS; k++) begin : g_sin
		gnpa_horner_cell #(.K(gnpa_pkg::SIN_DIV[k])) u_cell (
			.clk (clk),
			.en  (en),
			.x2_i(sx2[k]),
			.h_i (sh[k]),
			.x2_o(sx2[k+1]),
			.h_o (sh[k+1])
		);
	end

	gnpa_delay #(.W(30), .N(15)) u_th_dly (
		.clk(clk), .en(en), .d(th_s4), .q(th_s19)
	);

	assign snprod = 61'(th_s19) * 61'(sh[gnpa_pkg::SIN_TERMS]);

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s20 <= {1'b0, snprod[59:30]};
		end
	end

	gnpa_delay #(.W(31), .N(5)) u_sn_dly (
		.clk(clk), .en(en), .d(sn_s20), .q(sn_s25)
	);

	// octant flags to stage 25, select at 26
	logic [1:0]  flags_s25;
	logic [30:0] cmag_s26;
	logic        neg_s26;

	gnpa_delay #(.W(2), .N(23)) u_flag_dly (
		.clk(clk), .en(en), .d({neg_s2, sel_s2}), .q(flags_s25)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cmag_s26 <= flags_s25[0] ? sn_s25 : ch[gnpa_pkg::COS_TERMS];
			neg_s26 <= flags_s25[1];
		end
	end

	// align cos with radius, sd and pixel
	logic [31:0] cn_s46;
	logic [23:0] sd_s47;
	logic [7:0]  pix_s47;

	gnpa_delay #(.W(32), .N(20)) u_cos_dly (
		.clk(clk), .en(en), .d({neg_s26, cmag_s26}), .q(cn_s46)
	);

	gnpa_delay #(.W(24), .N(23)) u_sd_dly (
		.clk(clk), .en(en), .d(srt[24]), .q(sd_s47)
	);

	gnpa_delay #(.W(8), .N(46)) u_pix_dly (
		.clk(clk), .en(en), .d(pix_s1), .q(pix_s47)
	);

	// stages 47..49: z, noise, sum
	logic [49:0]        zprod;
	logic [18:0]        zmag_s47;
	logic               neg_s47, neg_s48;
	logic [42:0]        nmag_s48;
	logic signed [40:0] pix_sh;
	logic signed [40:0] mean_sh;
	logic signed [42:0] base_s48;
	logic signed [45:0] nsig;
	logic signed [45:0] sum_s49;

	assign zprod = 50'(rrt[19]) * 50'(cn_s46[30:0]);
	assign pix_sh = {1'b0, pix_s47, 32'b0};
	assign mean_sh = {mean_q, 24'b0};
	assign nsig = $signed({3'b000, nmag_s48});

	always_ff @(posedge clk) begin
		if (en) begin
			zmag_s47 <= zprod[48:30];
			neg_s47 <= cn_s46[31];
			nmag_s48 <= 43'(sd_s47) * 43'(zmag_s47);
			neg_s48 <= neg_s47;
			base_s48 <= 43'(pix_sh) + 43'(mean_sh);
			sum_s49 <= neg_s48 ? 46'(base_s48) - nsig : 46'(base_s48) + nsig;
		end
	end

	// clamp to 0..255 and drop the fraction
	always_comb begin
		if (sum_s49[45]) begin
			res = 8'd0;
		end else if (sum_s49[44:32] >= 13'd255) begin
			res = 8'd255;
		end else begin
			res = sum_s49[39:32];
		end
	end

	// skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s))
		else $error("pipeline moved while stalled");

	a_push_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !m_axis_tready) |=> skid_v_q)
		else $error("result lost while output stalled");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !out_v_q) |=> (m_axis_tvalid && m_axis_tdata == $past(res)))
		else $error("result not presented after leaving pipeline");

endmodule
`default_nettype wire
